FILE: sv/prdd_pkg.sv
// Package of the packet rate drop detector: sizes, codes, payload and
// control types shared by the interfaces, the controller and the datapath.
// Depends on nothing.
package prdd_pkg;

  // Ring and burst geometry (both powers of two)
  localparam int WINDOW_SLOTS = 16;
  localparam int INTERVAL_LEN = 64;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int ILEN_W       = $clog2(INTERVAL_LEN);
  localparam int BURST_W      = ILEN_W + 2;
  localparam int BURST_OFFSET = INTERVAL_LEN - WINDOW_SLOTS;

  // Field widths
  localparam int SEQ_W   = 31;
  localparam int RATE_W  = 32;
  localparam int TIME_W  = 32;
  localparam int Q_W     = 17;
  localparam int GRACE_W = 8;
  localparam int PBITS_W = 16;
  localparam int RUN_W   = 16;
  localparam int NUM_W   = ILEN_W + PBITS_W + 16;
  localparam int PROD_W  = Q_W + RATE_W;

  localparam logic [Q_W-1:0] Q16_ONE = Q_W'(65536);

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRED_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRACE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PBITS     = 3'd4;

  localparam logic [Q_W-1:0]     ALPHA_RESET  = 17'd6554;
  localparam logic [Q_W-1:0]     THRESH_RESET = 17'd62259;
  localparam logic [GRACE_W-1:0] GRACE_RESET  = 8'd3;
  localparam logic [PBITS_W-1:0] PBITS_RESET  = 16'd8192;

  // Packet kinds and report kinds
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_BURST = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_BURST = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SEQ_W-1:0]  seq_num;
    logic [RATE_W-1:0] sender_rate;
    logic [TIME_W-1:0] arrival_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        report_kind;
    logic [RATE_W-1:0] report_rate;
    logic [SEQ_W-1:0]  report_seq;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_SLOT, ST_BRD_LAST, ST_BRD_FIRST, ST_BDIV_START,
    ST_BDIV_WAIT, ST_EST, ST_EDIV_START, ST_EDIV_WAIT, ST_EW1, ST_EW2, ST_EW3,
    ST_THR1, ST_THR2, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_DECODE, OP_SLOT, OP_BRD_LAST, OP_BRD_FIRST,
    OP_BDIV_START, OP_BDIV_WAIT, OP_EST, OP_EDIV_START, OP_EDIV_WAIT,
    OP_EW1, OP_EW2, OP_EW3, OP_THR1, OP_THR2, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    EST_RATE, EST_EWMA, EST_AVG
  } est_sel_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic     is_start;
    logic     is_burst;
    logic     late;
    logic     burst_pending;
    est_sel_t est_sel;
    logic     nb_ok;
    logic     div_done;
    logic     pend_any;
    logic     out_space;
  } status_t;

endpackage

FILE: sv/prdd_if.sv
// Request channel interfaces of the packet rate drop detector.
// Depends on prdd_pkg for the payload types.
interface prdd_in_if import prdd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prdd_out_if import prdd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/prdd_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module prdd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/prdd_div.sv
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on prdd_pkg for the numerator width.
module prdd_div import prdd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [RATE_W-1:0] den,
  output logic              done,
  output logic [RATE_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              running;
  logic [CNT_W-1:0]  cnt;
  logic [RATE_W-1:0] rem;
  logic [NUM_W-1:0]  numsh;
  logic [NUM_W-1:0]  q;
  logic [RATE_W-1:0] den_r;
  logic [RATE_W:0]   trial;
  logic              fits;

  assign trial = {rem, numsh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Shift in one numerator bit and subtract where the divisor fits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      numsh <= num;
      q     <= '0;
      den_r <= den;
    end else if (running) begin
      rem   <= fits ? RATE_W'(trial - {1'b0, den_r}) : trial[RATE_W-1:0];
      numsh <= {numsh[NUM_W-2:0], 1'b0};
      q     <= {q[NUM_W-2:0], fits};
    end
  end

  // Saturate on a zero divisor or a quotient above 32 bits
  always_comb begin
    if (den_r == '0 || q[NUM_W-1:RATE_W] != '0) begin
      quot = '1;
    end else begin
      quot = q[RATE_W-1:0];
    end
  end

endmodule

FILE: sv/prdd_datapath.sv
// Datapath of the packet rate drop detector: configuration, ring state,
// arrival and burst memories, shared divider and multiplier, result registers.
// Depends on prdd_pkg, prdd_ram and prdd_div.
module prdd_datapath import prdd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  in_item_t               in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  logic                   out_ready,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  // Configuration registers
  logic               pred_mode;
  logic [Q_W-1:0]     alpha_q16;
  logic [Q_W-1:0]     threshold_q16;
  logic [GRACE_W-1:0] grace_count;
  logic [PBITS_W-1:0] packet_bits;

  // Latched request and block state
  in_item_t                  item;
  logic [SEQ_W-1:0]          expected_seq;
  logic [RATE_W-1:0]         current_rate;
  logic [RUN_W-1:0]          rate_run_count;
  logic [GRACE_W-1:0]        below_count;
  logic [RATE_W-1:0]         ewma_rate;
  logic [WINDOW_SLOTS-1:0]   received_flags;
  logic signed [BURST_W-1:0] burst_next;
  logic signed [BURST_W-1:0] burst_first;
  logic                      gap_big;
  logic [SLOT_W-1:0]         gap_lo;

  // Work registers
  logic [RATE_W-1:0] b_later;
  logic [RATE_W-1:0] est;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] acc;
  logic              pend0;
  logic [RATE_W-1:0] pend0_rate;
  logic              pend1;
  logic [1:0]        pend1_kind;
  logic [RATE_W-1:0] pend1_rate;

  logic [SEQ_W-1:0]          gap;
  logic [SLOT_W-1:0]         cur_slot;
  logic [SLOT_W-1:0]         nb_slot;
  logic signed [BURST_W-1:0] bi;
  logic                      bi_take;
  logic [Q_W-1:0]            alpha_sat;
  logic [Q_W-1:0]            mul_a;
  logic [RATE_W-1:0]         mul_b;
  logic [RATE_W-1:0]         arr_rdata;
  logic [RATE_W-1:0]         bst_rdata;
  logic [SLOT_W-1:0]         bst_raddr;
  logic                      div_start;
  logic [ILEN_W-1:0]         div_n;
  logic [RATE_W-1:0]         div_den;
  logic [ILEN_W+PBITS_W-1:0] div_np;
  logic [NUM_W-1:0]          div_num;
  logic                      div_done;
  logic [RATE_W-1:0]         div_quot;
  logic [PROD_W-1:0]         ewma_sum;
  est_sel_t                  est_sel;
  logic                      out_take;

  assign out_take  = out_valid && out_ready;
  assign gap       = item.seq_num - expected_seq;
  assign cur_slot  = item.seq_num[SLOT_W-1:0];
  assign bi        = $signed({{(BURST_W-ILEN_W){1'b0}}, item.seq_num[ILEN_W-1:0]})
                     - BURST_W'(BURST_OFFSET);
  assign bi_take   = bi >= burst_next;
  assign alpha_sat = (alpha_q16 > Q16_ONE) ? Q16_ONE : alpha_q16;

  // Pick the estimator from mode and run length
  always_comb begin
    if (!pred_mode && rate_run_count >= RUN_W'(2)) begin
      est_sel = EST_EWMA;
    end else if (pred_mode && rate_run_count >= RUN_W'(WINDOW_SLOTS)) begin
      est_sel = EST_AVG;
    end else begin
      est_sel = EST_RATE;
    end
  end

  assign nb_slot = (est_sel == EST_AVG) ? cur_slot + 1'b1 : cur_slot - 1'b1;

  always_comb begin
    status.is_start      = item.mode == MODE_START;
    status.is_burst      = item.mode == MODE_BURST;
    status.late          = item.seq_num < expected_seq;
    status.burst_pending = burst_next != '0 && (burst_next - 1'b1) != burst_first;
    status.est_sel       = est_sel;
    status.nb_ok         = received_flags[nb_slot];
    status.div_done      = div_done;
    status.pend_any      = pend0 || pend1;
    status.out_space     = !out_valid || out_ready;
  end

  // Arrival time and burst time memories
  prdd_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW_SLOTS)) u_arr_ram (
    .clk  (clk),
    .we   (cmd.op == OP_SLOT),
    .waddr(cur_slot),
    .wdata(item.arrival_us),
    .raddr(nb_slot),
    .rdata(arr_rdata)
  );

  assign bst_raddr = (cmd.op == OP_BRD_LAST) ? SLOT_W'(burst_next - 1'b1)
                                             : burst_first[SLOT_W-1:0];

  prdd_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW_SLOTS)) u_bst_ram (
    .clk  (clk),
    .we   (cmd.op == OP_SLOT && status.is_burst && bi_take),
    .waddr(bi[SLOT_W-1:0]),
    .wdata(item.arrival_us),
    .raddr(bst_raddr),
    .rdata(bst_rdata)
  );

  // Divider operands: burst span or neighbor interval
  always_comb begin
    div_start = 1'b0;
    div_n     = ILEN_W'(1);
    div_den   = item.arrival_us - arr_rdata;
    if (cmd.op == OP_BDIV_START) begin
      div_start = 1'b1;
      div_n     = ILEN_W'(burst_next - 1'b1 - burst_first);
      div_den   = b_later - bst_rdata;
    end else if (cmd.op == OP_EDIV_START) begin
      div_start = 1'b1;
      div_n     = (est_sel == EST_AVG) ? ILEN_W'(WINDOW_SLOTS - 1) : ILEN_W'(1);
    end
  end

  // Keep the full interval count times packet bits before scaling to 16.16
  assign div_np  = div_n * packet_bits;
  assign div_num = {div_np, 16'b0};

  prdd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  // Shared multiplier operands
  always_comb begin
    case (cmd.op)
      OP_EW1: begin
        mul_a = alpha_sat;
        mul_b = div_quot;
      end
      OP_EW2: begin
        mul_a = Q16_ONE - alpha_sat;
        mul_b = ewma_rate;
      end
      default: begin
        mul_a = threshold_q16;
        mul_b = item.sender_rate;
      end
    endcase
  end

  assign ewma_sum = acc + prod + PROD_W'(32768);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pred_mode     <= 1'b0;
      alpha_q16     <= ALPHA_RESET;
      threshold_q16 <= THRESH_RESET;
      grace_count   <= GRACE_RESET;
      packet_bits   <= PBITS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRED_MODE: pred_mode     <= cfg_wr_data[0];
        CFG_ALPHA:     alpha_q16     <= cfg_wr_data[Q_W-1:0];
        CFG_THRESHOLD: threshold_q16 <= cfg_wr_data[Q_W-1:0];
        CFG_GRACE:     grace_count   <= cfg_wr_data[GRACE_W-1:0];
        CFG_PBITS:     packet_bits   <= cfg_wr_data[PBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Block state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq   <= '0;
      current_rate   <= '0;
      rate_run_count <= '0;
      below_count    <= '0;
      ewma_rate      <= '0;
      received_flags <= '0;
      burst_next     <= '0;
      burst_first    <= '0;
      pend0          <= 1'b0;
      pend1          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_DECODE: begin
          if (status.is_start) begin
            expected_seq   <= '0;
            burst_next     <= '0;
            burst_first    <= '0;
            received_flags <= '0;
            pend1          <= 1'b1;
          end else if (item.sender_rate != current_rate) begin
            current_rate   <= item.sender_rate;
            rate_run_count <= RUN_W'(1);
          end else if (rate_run_count != '1) begin
            rate_run_count <= rate_run_count + 1'b1;
          end
        end
        OP_SLOT: begin
          // Clear skipped slots, mark this one
          for (int j = 0; j < WINDOW_SLOTS; j++) begin
            if (SLOT_W'(j) == cur_slot) begin
              received_flags[j] <= 1'b1;
            end else if (gap_big || (SLOT_W'(j) - expected_seq[SLOT_W-1:0]) < gap_lo) begin
              received_flags[j] <= 1'b0;
            end
          end
          if (status.is_burst) begin
            expected_seq <= item.seq_num + 1'b1;
            if (bi_take) begin
              if (burst_next == '0) begin
                burst_first <= bi;
              end
              burst_next <= bi + 1'b1;
            end
          end
        end
        OP_BDIV_WAIT: begin
          if (div_done) begin
            pend0      <= 1'b1;
            burst_next <= '0;
          end
        end
        OP_EW3: begin
          ewma_rate <= ewma_sum[RATE_W+15:16];
        end
        OP_THR2: begin
          expected_seq <= item.seq_num + 1'b1;
          if ({est, 16'b0} <= prod) begin
            if (below_count == grace_count) begin
              pend1       <= 1'b1;
              below_count <= '0;
            end else begin
              below_count <= below_count + 1'b1;
            end
          end else begin
            below_count <= '0;
          end
        end
        OP_EMIT: begin
          out_valid <= 1'b1;
          if (pend0) begin
            pend0 <= 1'b0;
          end else begin
            pend1 <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: item <= in_data;
      OP_DECODE: begin
        gap_big    <= gap >= SEQ_W'(WINDOW_SLOTS);
        gap_lo     <= gap[SLOT_W-1:0];
        pend1_kind <= KIND_ACK;
        pend1_rate <= '0;
      end
      OP_BRD_FIRST: b_later <= bst_rdata;
      OP_BDIV_WAIT: pend0_rate <= div_quot;
      OP_EST: est <= item.sender_rate;
      OP_EDIV_WAIT: est <= div_quot;
      OP_EW1: prod <= mul_a * mul_b;
      OP_EW2: begin
        acc  <= prod;
        prod <= mul_a * mul_b;
      end
      OP_EW3: est <= ewma_sum[RATE_W+15:16];
      OP_THR1: prod <= mul_a * mul_b;
      OP_THR2: begin
        pend1_kind <= KIND_DROP;
        pend1_rate <= est;
      end
      OP_EMIT: begin
        if (pend0) begin
          out_data <= '{report_kind: KIND_BURST, report_rate: pend0_rate,
                        report_seq: item.seq_num, last: !pend1};
        end else begin
          out_data <= '{report_kind: pend1_kind, report_rate: pend1_rate,
                        report_seq: (pend1_kind == KIND_ACK) ? '0 : item.seq_num,
                        last: 1'b1};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/prdd_ctrl.sv
// Controller state machine of the packet rate drop detector.
// Depends on prdd_pkg for state, command and status types.
module prdd_ctrl import prdd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.is_start)  state_next = ST_EMIT;
        else if (status.late) state_next = ST_IDLE;
        else                  state_next = ST_SLOT;
      end
      ST_SLOT: begin
        if (status.is_burst)           state_next = ST_IDLE;
        else if (status.burst_pending) state_next = ST_BRD_LAST;
        else                           state_next = ST_EST;
      end
      ST_BRD_LAST:   state_next = ST_BRD_FIRST;
      ST_BRD_FIRST:  state_next = ST_BDIV_START;
      ST_BDIV_START: state_next = ST_BDIV_WAIT;
      ST_BDIV_WAIT: begin
        if (status.div_done) state_next = ST_EST;
      end
      ST_EST: begin
        if (status.est_sel == EST_RATE) state_next = ST_THR1;
        else if (!status.nb_ok)         state_next = ST_EMIT;
        else                            state_next = ST_EDIV_START;
      end
      ST_EDIV_START: state_next = ST_EDIV_WAIT;
      ST_EDIV_WAIT: begin
        if (status.div_done) begin
          state_next = (status.est_sel == EST_EWMA) ? ST_EW1 : ST_THR1;
        end
      end
      ST_EW1:  state_next = ST_EW2;
      ST_EW2:  state_next = ST_EW3;
      ST_EW3:  state_next = ST_THR1;
      ST_THR1: state_next = ST_THR2;
      ST_THR2: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.pend_any) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = state == ST_IDLE;
    cmd.op   = OP_NONE;
    case (state)
      ST_IDLE:       if (in_valid) cmd.op = OP_ACCEPT;
      ST_DECODE:     cmd.op = OP_DECODE;
      ST_SLOT:       cmd.op = OP_SLOT;
      ST_BRD_LAST:   cmd.op = OP_BRD_LAST;
      ST_BRD_FIRST:  cmd.op = OP_BRD_FIRST;
      ST_BDIV_START: cmd.op = OP_BDIV_START;
      ST_BDIV_WAIT:  cmd.op = OP_BDIV_WAIT;
      ST_EST:        cmd.op = OP_EST;
      ST_EDIV_START: cmd.op = OP_EDIV_START;
      ST_EDIV_WAIT:  cmd.op = OP_EDIV_WAIT;
      ST_EW1:        cmd.op = OP_EW1;
      ST_EW2:        cmd.op = OP_EW2;
      ST_EW3:        cmd.op = OP_EW3;
      ST_THR1:       cmd.op = OP_THR1;
      ST_THR2:       cmd.op = OP_THR2;
      ST_EMIT:       if (status.pend_any && status.out_space) cmd.op = OP_EMIT;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: sv/packet_rate_drop_detector.sv
// Top level of the packet rate drop detector: controller plus datapath.
// Depends on prdd_pkg, prdd_if, prdd_ctrl and prdd_datapath.
//
//   channel  direction  payload
//   pkt      in         mode, seq_num, sender_rate, arrival_us
//   rpt      out        report_kind, report_rate, report_seq, last
//   cfg      in         cfg_wr_en, cfg_index, cfg_wr_data (write only)
//
// One request at a time, with output stalls on top; a plain packet may use the
// bit-serial divider once for a burst report and once for the neighbor interval.
// Synchronous active-high reset clears all control state and the flags.
// A result waits in the output register; the next request is taken while it
// waits, and a second result stalls the controller until the first is taken.
module packet_rate_drop_detector import prdd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  prdd_in_if.sink                pkt,
  prdd_out_if.source             rpt,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  prdd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(pkt.valid),
    .in_ready(pkt.ready),
    .status  (status),
    .cmd     (cmd)
  );

  prdd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_data    (pkt.data),
    .out_valid  (rpt.valid),
    .out_data   (rpt.data),
    .out_ready  (rpt.ready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

endmodule

FILE: tb/prdd_report_checker.sv
// Report checker for the packet rate drop detector: watches the packet,
// report and register channels, predicts every report and compares it.
// Depends on prdd_pkg and the prdd_in_if / prdd_out_if interfaces.
module prdd_report_checker import prdd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  prdd_in_if                     pkt,
  prdd_out_if                    rpt,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  output int                     mismatches,
  output int                     pending,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic               avg_mode;
  logic [Q_W-1:0]     alpha;
  logic [Q_W-1:0]     thresh;
  logic [GRACE_W-1:0] grace;
  logic [PBITS_W-1:0] pbits;

  // Detector state copy
  logic [SEQ_W-1:0]  next_seq;
  logic [RATE_W-1:0] claimed_rate;
  logic [RUN_W-1:0]  run_len;
  logic [7:0]        below_run;
  logic [RATE_W-1:0] smoothed;
  logic [TIME_W-1:0] arrival_ring [WINDOW_SLOTS];
  logic              seen_ring [WINDOW_SLOTS];
  logic [TIME_W-1:0] burst_ring [WINDOW_SLOTS];
  int                burst_tail;
  int                burst_head;

  out_item_t reports_due[$];

  function automatic int ring_slot(longint v);
    longint r;
    r = v % WINDOW_SLOTS;
    if (r < 0) r += WINDOW_SLOTS;
    return int'(r);
  endfunction

  // Packets per interval turned into Mbps 16.16, saturating
  function automatic logic [RATE_W-1:0] interval_rate(logic [TIME_W-1:0] later,
      logic [TIME_W-1:0] earlier, longint unsigned n);
    logic [TIME_W-1:0] d;
    longint unsigned q;
    d = later - earlier;
    if (d == 0) return '1;
    q = (n * longint'(pbits) * 64'd65536) / longint'(d);
    return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
  endfunction

  task automatic predict_reports(input in_item_t it);
    logic [RATE_W-1:0] est;
    logic [RATE_W-1:0] spd;
    longint unsigned   a;
    longint unsigned   gap;
    out_item_t         r [2];
    int                n;
    int                idx;
    int                p;
    int                bi;
    bit                halt;
    n = 0;
    halt = 0;
    if (it.mode == MODE_START) begin
      next_seq = '0;
      burst_tail = 0;
      burst_head = 0;
      for (int k = 0; k < WINDOW_SLOTS; k++) seen_ring[k] = 1'b0;
      r[0].report_kind = KIND_ACK;
      r[0].report_rate = '0;
      r[0].report_seq  = '0;
      r[0].last        = 1'b1;
      reports_due.push_back(r[0]);
      return;
    end
    if (it.sender_rate != claimed_rate) begin
      claimed_rate = it.sender_rate;
      run_len = '0;
    end
    if (run_len != 16'hFFFF) run_len++;
    // Drop late packets
    if (it.seq_num < next_seq) return;
    // Clear skipped slots
    gap = longint'(it.seq_num) - longint'(next_seq);
    if (gap >= WINDOW_SLOTS) begin
      for (int k = 0; k < WINDOW_SLOTS; k++) seen_ring[k] = 1'b0;
    end else begin
      for (int k = 0; k < int'(gap); k++) seen_ring[ring_slot(longint'(next_seq) + k)] = 1'b0;
    end
    idx = ring_slot(longint'(it.seq_num));
    seen_ring[idx] = 1'b1;
    arrival_ring[idx] = it.arrival_us;
    if (it.mode == MODE_BURST) begin
      bi = int'(it.seq_num % INTERVAL_LEN) - BURST_OFFSET;
      if (bi >= burst_tail) begin
        if (burst_tail == 0) burst_head = bi;
        burst_ring[ring_slot(bi)] = it.arrival_us;
        burst_tail = bi + 1;
      end
    end else begin
      // Close the burst
      if (burst_tail != 0 && burst_tail - 1 != burst_head) begin
        spd = interval_rate(burst_ring[ring_slot(burst_tail - 1)],
                            burst_ring[ring_slot(burst_head)],
                            longint'(burst_tail - 1 - burst_head));
        r[n].report_kind = KIND_BURST;
        r[n].report_rate = spd;
        r[n].report_seq  = it.seq_num;
        r[n].last        = 1'b0;
        n++;
        burst_tail = 0;
      end
      est = it.sender_rate;
      if (!avg_mode && run_len >= 2) begin
        p = ring_slot(longint'(it.seq_num) - 1);
        if (!seen_ring[p]) begin
          halt = 1;
        end else begin
          a = (alpha > Q16_ONE) ? 64'd65536 : longint'(alpha);
          spd = interval_rate(arrival_ring[idx], arrival_ring[p], 1);
          smoothed = 32'((a * spd + (64'd65536 - a) * smoothed + 64'd32768) >> 16);
          est = smoothed;
        end
      end
      if (!halt && avg_mode && run_len >= WINDOW_SLOTS) begin
        p = ring_slot(longint'(it.seq_num) + 1);
        if (!seen_ring[p]) halt = 1;
        else est = interval_rate(arrival_ring[idx], arrival_ring[p], WINDOW_SLOTS - 1);
      end
      // Threshold against the claimed rate
      if (!halt) begin
        if (longint'(est) * 64'd65536 <= longint'(thresh) * longint'(it.sender_rate)) begin
          if (below_run == grace) begin
            r[n].report_kind = KIND_DROP;
            r[n].report_rate = est;
            r[n].report_seq  = it.seq_num;
            r[n].last        = 1'b0;
            n++;
            below_run = '0;
          end else begin
            below_run = below_run + 8'd1;
          end
        end else begin
          below_run = '0;
        end
      end
    end
    if (!halt) next_seq = it.seq_num + 31'd1;
    for (int k = 0; k < n; k++) begin
      r[k].last = (k == n - 1);
      reports_due.push_back(r[k]);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      avg_mode = 1'b0;
      alpha = ALPHA_RESET;
      thresh = THRESH_RESET;
      grace = GRACE_RESET;
      pbits = PBITS_RESET;
      next_seq = '0;
      claimed_rate = '0;
      run_len = '0;
      below_run = '0;
      smoothed = '0;
      burst_tail = 0;
      burst_head = 0;
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        seen_ring[k] = 1'b0;
        arrival_ring[k] = '0;
        burst_ring[k] = '0;
      end
      reports_due.delete();
      mismatches <= 0;
      checked <= 0;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PRED_MODE: avg_mode = cfg_wr_data[0];
          CFG_ALPHA:     alpha = cfg_wr_data;
          CFG_THRESHOLD: thresh = cfg_wr_data;
          CFG_GRACE:     grace = cfg_wr_data[7:0];
          CFG_PBITS:     pbits = cfg_wr_data[15:0];
          default: ;
        endcase
      end
      if (pkt.valid && pkt.ready) predict_reports(pkt.data);
      // Compare each report with the oldest prediction
      if (rpt.valid && rpt.ready) begin
        got = rpt.data;
        checked <= checked + 1;
        if (reports_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected report kind=%0d rate=%h seq=%h last=%b",
            got.report_kind, got.report_rate, got.report_seq, got.last);
          mismatches <= mismatches + 1;
        end else begin
          want = reports_due.pop_front();
          if (got.report_kind !== want.report_kind || got.report_rate !== want.report_rate ||
              got.report_seq !== want.report_seq || got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("report mismatch: expected kind=%0d rate=%h seq=%h last=%b",
                want.report_kind, want.report_rate, want.report_seq, want.last);
              $display("                 actual   kind=%0d rate=%h seq=%h last=%b",
                got.report_kind, got.report_rate, got.report_seq, got.last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= reports_due.size();
  end

endmodule

FILE: tb/packet_rate_drop_detector_test.sv
// Stimulus top for the packet rate drop detector: clock, reset, register
// phases, probe packet sequences with bursty sender and stalling receiver.
// Depends on prdd_pkg, prdd_if, the detector RTL and prdd_report_checker.
module packet_rate_drop_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prdd_pkg::*;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int SETTLE      = 200;
  localparam int ITEM_TARGET = 600;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;
  int                     mismatches;
  int                     pending;
  int                     checked;
  int                     cycles;
  int                     sent;
  int                     phases;
  int                     burst_left;
  bit                     hold_req;
  int                     hold_left;
  int                     stall_style;
  int                     style_cnt;
  int                     stall_left;

  prdd_in_if  pkt ();
  prdd_out_if rpt ();

  packet_rate_drop_detector dut (
    .clk(clk), .rst(rst), .pkt(pkt), .rpt(rpt),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  prdd_report_checker checker_i (
    .clk(clk), .rst(rst), .pkt(pkt), .rpt(rpt),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Abort on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall styles that change over time, plus a long hold-off
  initial begin
    rpt.ready = 1'b0;
    stall_style = 0;
    style_cnt = 0;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rpt.ready <= 1'b0;
        hold_left = 400;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        hold_req = 0;
      end else begin
        case (stall_style)
          0: rpt.ready <= 1'b1;
          1: rpt.ready <= $urandom_range(0, 1);
          2: rpt.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              rpt.ready <= 1'b0;
            end else begin
              rpt.ready <= 1'b1;
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
            end
          end
        endcase
      end
      style_cnt++;
      if (style_cnt >= 97) begin
        style_cnt = 0;
        stall_style = $urandom_range(0, 3);
      end
    end
  end

  // Offer one packet; hold it until taken, with gaps between bursts
  task automatic send_pkt(input logic [1:0] mode, input logic [SEQ_W-1:0] seq,
      input logic [RATE_W-1:0] rate, input logic [TIME_W-1:0] t);
    in_item_t it;
    bit       taken;
    int       gap;
    it.mode = mode;
    it.seq_num = seq;
    it.sender_rate = rate;
    it.arrival_us = t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        pkt.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pkt.valid <= 1'b1;
    pkt.data <= it;
    do begin
      @(negedge clk);
      taken = pkt.ready;
      @(posedge clk);
    end while (!taken);
    burst_left--;
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Drain outstanding reports, then let late work finish
  task automatic wait_idle();
    @(posedge clk);
    pkt.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_q16();
    case ($urandom_range(0, 4))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return $urandom_range(40000, 70000);
    endcase
  endfunction

  task automatic write_all_regs();
    logic [CFG_DATA_W-1:0] pb;
    write_reg(CFG_PRED_MODE, $urandom_range(0, 1));
    write_reg(CFG_ALPHA, pick_q16());
    write_reg(CFG_THRESHOLD, pick_q16());
    case ($urandom_range(0, 3))
      0: write_reg(CFG_GRACE, 17'd0);
      1: write_reg(CFG_GRACE, 17'd255);
      default: write_reg(CFG_GRACE, $urandom_range(0, 5));
    endcase
    case ($urandom_range(0, 5))
      0: pb = 17'd0;
      1: pb = 17'd1;
      2: pb = 17'd65535;
      default: pb = $urandom_range(1000, 20000);
    endcase
    write_reg(CFG_PBITS, pb);
  endtask

  // Start, a burst near the end of an interval, then a run of plain packets
  task automatic probe_sequence();
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] t;
    logic [RATE_W-1:0] rate;
    int                base;
    int                first;
    int                plain_n;
    send_pkt(MODE_START, $urandom, $urandom, $urandom);
    seq = ($urandom_range(0, 7) == 0) ? 31'h7FFF_FFC0 : 31'($urandom_range(0, 1 << 20) * 64);
    first = $urandom_range(BURST_OFFSET, INTERVAL_LEN - 1);
    seq = seq + first;
    t = $urandom;
    base = $urandom_range(20, 400);
    rate = 32'((longint'(8192) * 65536) / base);
    if ($urandom_range(0, 1)) rate = rate + $urandom_range(0, 1 << 22) - (1 << 21);
    for (int k = first; k < INTERVAL_LEN; k++) begin
      if ($urandom_range(0, 5) != 0)
        send_pkt(MODE_BURST, seq, rate, t);
      seq++;
      t = t + $urandom_range(base / 2, base);
    end
    plain_n = $urandom_range(10, 40);
    for (int k = 0; k < plain_n; k++) begin
      case ($urandom_range(0, 19))
        0: send_pkt($urandom_range(0, 3), $urandom, $urandom, $urandom);
        1: send_pkt(MODE_PLAIN, seq - $urandom_range(1, 20), rate, t);
        2: begin
          seq = seq + $urandom_range(1, 20);
          send_pkt(MODE_PLAIN, seq, rate, t);
        end
        3: send_pkt(2'd3, seq, rate, t);
        default: send_pkt(MODE_PLAIN, seq, rate, t);
      endcase
      seq++;
      t = t + (($urandom_range(0, 3) == 0) ? $urandom_range(base, base * 4)
                                           : $urandom_range(base - base / 8, base + base / 8));
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    sent = 0;
    phases = 0;
    burst_left = 0;
    hold_req = 0;
    pkt.valid = 1'b0;
    pkt.data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers, burst report, zero interval, late, skips, wraps
    write_reg(CFG_PRED_MODE, 17'd0);
    write_reg(CFG_GRACE, 17'd0);
    send_pkt(MODE_START, 31'd0, 32'd0, 32'd0);
    send_pkt(MODE_BURST, 31'd48, 32'd5368709, 32'd1000);
    send_pkt(MODE_BURST, 31'd49, 32'd5368709, 32'd1100);
    send_pkt(MODE_BURST, 31'd50, 32'd5368709, 32'd1200);
    send_pkt(MODE_PLAIN, 31'd51, 32'd5368709, 32'd1300);
    send_pkt(MODE_PLAIN, 31'd52, 32'd5368709, 32'd1300);
    send_pkt(2'd3, 31'd53, 32'd5368709, 32'd1400);
    send_pkt(MODE_PLAIN, 31'd10, 32'd5368709, 32'd1500);
    send_pkt(MODE_PLAIN, 31'd54, 32'd0, 32'd1500);
    send_pkt(MODE_PLAIN, 31'd55, 32'hFFFF_FFFF, 32'd1600);
    send_pkt(MODE_PLAIN, 31'd80, 32'hFFFF_FFFF, 32'd1700);
    send_pkt(MODE_PLAIN, 31'd81, 32'hFFFF_FFFF, 32'd1800);
    send_pkt(MODE_PLAIN, 31'd90, 32'hFFFF_FFFF, 32'd1900);
    send_pkt(MODE_BURST, 31'd112, 32'd1000, 32'd2000);
    send_pkt(MODE_PLAIN, 31'd113, 32'd1000, 32'd2100);
    send_pkt(MODE_PLAIN, 31'd114, 32'd1000, 32'hFFFF_FFF0);
    send_pkt(MODE_PLAIN, 31'd115, 32'd1000, 32'd20);
    send_pkt(MODE_BURST, 31'd127, 32'd1000, 32'd40);
    send_pkt(MODE_START, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pkt(MODE_BURST, 31'd200, 32'd1000, 32'd50);
    send_pkt(MODE_PLAIN, 31'h7FFF_FFFE, 32'd1000, 32'd60);
    send_pkt(MODE_PLAIN, 31'h7FFF_FFFF, 32'd1000, 32'd70);
    send_pkt(MODE_PLAIN, 31'd0, 32'd1000, 32'd80);
    wait_idle();

    // Random phases, each under fresh register settings
    while (sent < ITEM_TARGET) begin
      write_all_regs();
      if (phases == 2) hold_req = 1;
      repeat (2) probe_sequence();
      wait_idle();
      phases++;
    end

    $display("sent %0d packets over %0d register phases, checked %0d reports",
      sent, phases, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
